### rtl/core/evis_pkg.sv
// Package for the event interval statistics block: field widths, stream packing
// and operation codes shared by the top level and the port checker.
// Depends on nothing.
`default_nettype none

package evis_pkg;

   // Default parameter values of the top level.
   localparam int CHANNELS_DEF    = 4;
   localparam int MAX_SAMPLES_DEF = 1024;
   localparam int TIME_BITS_DEF   = 48;

   // Input item fields.
   localparam int OP_W    = 1;
   localparam int CHAN_W  = 2;
   localparam int STAMP_W = 48;

   // Result item fields.
   localparam int OUT_W     = 48;
   localparam int CNT_OUT_W = 11;

   // Stream packing, padded to whole bytes.
   localparam int REQ_FIELD_W = CHAN_W + STAMP_W;
   localparam int REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = 3 * OUT_W + CNT_OUT_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   // Operation codes carried in req_tuser.
   localparam logic [OP_W-1:0] OP_MARK = 1'b0;
   localparam logic [OP_W-1:0] OP_READ = 1'b1;

endpackage

`default_nettype wire

### rtl/core/evis_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Used by the top level for the average; depends on nothing.
`default_nettype none

module evis_divider #(
   parameter int NUM_W = 58,
   parameter int DEN_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             busy,
   output logic [NUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   // Shift the next dividend bit into the partial remainder and try a subtract.
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   // The dividend shifts out at the top while quotient bits shift in at the bottom.
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(NUM_W);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         step_in = step_ff - 1'b1;
         busy_in = (step_ff != STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### rtl/core/event_interval_statistics_top.sv
// Top level of the per-channel event interval monitor.
// Depends on evis_pkg and evis_divider.
//
//   Group   Dir  Transfer carries                   Packing (low bit first)
//   req_*   in   mark or read item                  tuser: op; tdata: channel, timestamp
//   rsp_*   out  statistics of one read             tdata: min, max, avg, count
//
// A mark: accept with memory read, delta in ST_LOAD, update and write in ST_MARK, which is
// skipped for a bad channel or a full count. A read: ST_LOAD, then ST_DIV while the serial
// divider forms the average, one quotient bit per cycle, then ST_EMIT (no ST_DIV if empty).
// One item is in work at a time; a new item is taken while a result waits in rsp_tdata.
// Synchronous reset clears control state and the per-entry valid bits; an entry whose
// valid bit is clear reads as all zero, so no clearing pass is needed.
`default_nettype none

module event_interval_statistics_top import evis_pkg::*; #(
   parameter int CHANNELS    = CHANNELS_DEF,
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int TIME_BITS   = TIME_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request stream.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // channel, timestamp, zero pad
   input  logic [OP_W-1:0]        req_tuser,   // op
   // Result stream.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // min, max, avg, count, zero pad
);

   localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_BITS  = $clog2(MAX_SAMPLES + 1);
   localparam int KEEP_BITS = (TIME_BITS < STAMP_W) ? TIME_BITS : STAMP_W;
   localparam int SUM_RAW   = TIME_BITS + $clog2(MAX_SAMPLES);
   localparam int SUM_BITS  = (SUM_RAW < 64) ? SUM_RAW : 64;

   typedef struct packed {
      logic                 stamp_valid;
      logic [KEEP_BITS-1:0] last_stamp;
      logic [CNT_BITS-1:0]  count;
      logic [SUM_BITS-1:0]  sum;
      logic [TIME_BITS-1:0] dmin;
      logic [TIME_BITS-1:0] dmax;
   } entry_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LOAD = 5'b00010,
      ST_MARK = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [OP_W-1:0]        op_ff, op_in;
   logic                   chan_ok_ff, chan_ok_in;
   logic [CH_IDX_W-1:0]    idx_ff, idx_in;
   logic [KEEP_BITS-1:0]   stamp_ff, stamp_in;
   logic [TIME_BITS-1:0]   delta_ff, delta_in;
   logic [CHANNELS-1:0]    entry_valid_ff, entry_valid_in;
   entry_type              rd_data_ff;
   logic [OUT_W-1:0]       res_min_ff, res_min_in;
   logic [OUT_W-1:0]       res_max_ff, res_max_in;
   logic [CNT_OUT_W-1:0]   res_cnt_ff, res_cnt_in;
   logic                   res_zero_ff, res_zero_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   entry_type              stat_mem [CHANNELS];
   entry_type              cur;
   entry_type              mem_wdata;
   logic                   mem_we;

   logic                   req_accept;
   logic [CHAN_W-1:0]      req_chan;
   logic [STAMP_W-1:0]     req_stamp;
   logic                   req_chan_ok;
   logic                   slot_free;
   logic                   div_start;
   logic                   div_busy;
   logic [SUM_BITS-1:0]    div_quotient;
   logic [OUT_W-1:0]       avg_out;

   // Request decode.
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid & req_tready;
   assign req_chan    = req_tdata[CHAN_W-1:0];
   assign req_stamp   = req_tdata[CHAN_W +: STAMP_W];
   assign req_chan_ok = (32'(req_chan) < 32'(CHANNELS));

   // Statistics memory: read issued on accept, written back by the update states.
   always_ff @(posedge clock) begin
      if (req_accept && req_chan_ok) begin
         rd_data_ff <= stat_mem[CH_IDX_W'(req_chan)];
      end
      if (mem_we) begin
         stat_mem[idx_ff] <= mem_wdata;
      end
   end

   // An entry never written since reset reads as all zero.
   assign cur = entry_valid_ff[idx_ff] ? rd_data_ff : '0;

   assign slot_free = !rsp_tvalid_ff || rsp_tready;
   assign avg_out   = res_zero_ff ? '0 : OUT_W'(div_quotient);

   // Sequencer: one item at a time, read, modify, write back.
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      chan_ok_in     = chan_ok_ff;
      idx_in         = idx_ff;
      stamp_in       = stamp_ff;
      delta_in       = delta_ff;
      entry_valid_in = entry_valid_ff;
      res_min_in     = res_min_ff;
      res_max_in     = res_max_ff;
      res_cnt_in     = res_cnt_ff;
      res_zero_in    = res_zero_ff;
      rsp_tvalid_in  = rsp_tvalid_ff;
      rsp_tdata_in   = rsp_tdata_ff;
      mem_we         = 1'b0;
      mem_wdata      = '0;
      div_start      = 1'b0;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in      = req_tuser;
               chan_ok_in = req_chan_ok;
               idx_in     = CH_IDX_W'(req_chan);
               stamp_in   = KEEP_BITS'(req_stamp);
               state_in   = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (op_ff == OP_MARK) begin
               // Delta modulo the counter width, zero before the first mark.
               if (cur.stamp_valid) begin
                  delta_in = TIME_BITS'(stamp_ff) - TIME_BITS'(cur.last_stamp);
               end else begin
                  delta_in = '0;
               end
               if (chan_ok_ff && (cur.count < CNT_BITS'(MAX_SAMPLES))) begin
                  state_in = ST_MARK;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               res_min_in  = OUT_W'(cur.dmin);
               res_max_in  = OUT_W'(cur.dmax);
               res_cnt_in  = CNT_OUT_W'(cur.count);
               res_zero_in = !chan_ok_ff || (cur.count == '0);
               if (chan_ok_ff) begin
                  // Clear the statistics but keep the last timestamp.
                  mem_we                 = 1'b1;
                  mem_wdata.stamp_valid  = cur.stamp_valid;
                  mem_wdata.last_stamp   = cur.last_stamp;
                  entry_valid_in[idx_ff] = 1'b1;
               end
               if (!chan_ok_ff || (cur.count == '0)) begin
                  state_in = ST_EMIT;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_MARK: begin
            mem_we                = 1'b1;
            mem_wdata.stamp_valid = 1'b1;
            mem_wdata.last_stamp  = stamp_ff;
            mem_wdata.count       = cur.count + CNT_BITS'(1);
            mem_wdata.sum         = cur.sum + SUM_BITS'(delta_ff);
            mem_wdata.dmin = ((cur.count == '0) || (delta_ff < cur.dmin)) ? delta_ff : cur.dmin;
            mem_wdata.dmax = ((cur.count == '0) || (delta_ff > cur.dmax)) ? delta_ff : cur.dmax;
            entry_valid_in[idx_ff] = 1'b1;
            state_in               = ST_IDLE;
         end
         ST_DIV: begin
            if (!div_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Hand the result to the output register once it is free.
            if (slot_free) begin
               rsp_tvalid_in = 1'b1;
               if (res_zero_ff) begin
                  rsp_tdata_in = '0;
               end else begin
                  rsp_tdata_in = RSP_TDATA_W'({res_cnt_ff, avg_out, res_max_ff, res_min_ff});
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_valid_ff <= '0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_valid_ff <= entry_valid_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
      op_ff        <= op_in;
      chan_ok_ff   <= chan_ok_in;
      idx_ff       <= idx_in;
      stamp_ff     <= stamp_in;
      delta_ff     <= delta_in;
      res_min_ff   <= res_min_in;
      res_max_ff   <= res_max_in;
      res_cnt_ff   <= res_cnt_in;
      res_zero_ff  <= res_zero_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // Serial divider for the average.
   evis_divider #(
      .NUM_W (SUM_BITS),
      .DEN_W (CNT_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cur.sum),
      .divisor  (cur.count),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire

### rtl/core/evis_checker.sv
// Port-level checker for the event interval monitor, bound to the top level.
// Depends on evis_pkg.
`default_nettype none

module evis_checker import evis_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int TIME_BITS   = TIME_BITS_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam bit EXACT = (TIME_BITS <= OUT_W) && (MAX_SAMPLES < (1 << CNT_OUT_W));

   logic [OUT_W-1:0]     min_f;
   logic [OUT_W-1:0]     max_f;
   logic [OUT_W-1:0]     avg_f;
   logic [CNT_OUT_W-1:0] cnt_f;

   assign min_f = rsp_tdata[0 +: OUT_W];
   assign max_f = rsp_tdata[OUT_W +: OUT_W];
   assign avg_f = rsp_tdata[2 * OUT_W +: OUT_W];
   assign cnt_f = rsp_tdata[3 * OUT_W +: CNT_OUT_W];

   // No result is offered right after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // With exact result fields, an empty channel reports all zeros.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && EXACT && (cnt_f == '0) |-> (rsp_tdata == '0))
      else $error("empty result not zero");

   // With exact result fields, the average lies between the smallest and the largest interval.
   a_avg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && EXACT && (cnt_f != '0) |-> (min_f <= avg_f) && (avg_f <= max_f))
      else $error("average outside min and max");

   // With exact result fields, the count never exceeds the sample limit.
   a_cnt_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && EXACT |-> (32'(cnt_f) <= 32'(MAX_SAMPLES)))
      else $error("count beyond sample limit");

endmodule

bind event_interval_statistics_top evis_checker #(
   .MAX_SAMPLES (MAX_SAMPLES),
   .TIME_BITS   (TIME_BITS)
) u_evis_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
